@@ rtl/sca_pkg.sv @@
// Shared types, codes and size-class helpers for the slab allocator.
`default_nettype none
package sca_pkg;

    localparam int POOL_PAGES_DEF = 16;
    localparam int CLASS_COUNT    = 9;
    localparam int SLOTS_PER_PAGE = 256;
    localparam logic [11:0] MAX_REQUEST  = 12'd4080;
    localparam logic [11:0] HEADER_BYTES = 12'd16;

    typedef logic [3:0] t_cls;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TOO_BIG = 2'd1;
    localparam logic [1:0] ST_NO_PAGE = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_FILL,
        S_POP_RD,
        S_POP_WR,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE_LNK,
        S_PUSH_A,
        S_PUSH_B,
        S_UNL_RD,
        S_UNL_WR
    } t_state;

    function automatic t_cls size_class(input logic [11:0] size);
        t_cls c;
        if (size <= 12'd16)        c = 4'd0;
        else if (size <= 12'd32)   c = 4'd1;
        else if (size <= 12'd64)   c = 4'd2;
        else if (size <= 12'd128)  c = 4'd3;
        else if (size <= 12'd256)  c = 4'd4;
        else if (size <= 12'd512)  c = 4'd5;
        else if (size <= 12'd1024) c = 4'd6;
        else if (size <= 12'd2048) c = 4'd7;
        else                       c = 4'd8;
        return c;
    endfunction

    function automatic logic [7:0] slot_count(input t_cls c);
        logic [7:0] n;
        case (c)
            4'd0:    n = 8'd255;
            4'd1:    n = 8'd127;
            4'd2:    n = 8'd63;
            4'd3:    n = 8'd31;
            4'd4:    n = 8'd15;
            4'd5:    n = 8'd7;
            4'd6:    n = 8'd3;
            default: n = 8'd1;
        endcase
        return n;
    endfunction

    function automatic logic [11:0] slot_offset(input t_cls c, input logic [7:0] slot);
        logic [11:0] o;
        if (c < 4'd8) o = 12'({4'd0, slot} << (c + 4'd4));
        else          o = 12'd0;
        return o;
    endfunction

endpackage
`default_nettype wire

@@ rtl/sca_if.sv @@
// Request and response channel interfaces of the slab allocator.
`default_nettype none
interface sca_req_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [11:0] request_size;
    logic [15:0] block_address;
    modport source (output valid, opcode, request_size, block_address, input ready);
    modport sink   (input valid, opcode, request_size, block_address, output ready);
endinterface

interface sca_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] granted_address;
    logic [1:0]  status;
    modport source (output valid, granted_address, status, input ready);
    modport sink   (input valid, granted_address, status, output ready);
endinterface
`default_nettype wire

@@ rtl/size_class_slab_allocator.sv @@
// Size-class slab allocator: request channel in, one response per request out.
// Usage: send a request on i_req (opcode 0 allocate with request_size, opcode 1
// free with block_address). Each request yields exactly one response on o_rsp
// with granted_address and status (0 ok, 1 too large, 2 pool exhausted).
// One request is in flight at a time; i_req.ready is high while the sequencer
// is idle and the response register is empty or being taken.
// Steps to the response register: a too-large allocate answers from idle; an
//   allocate from a non-empty list reads the head and then pops it; one that
//   needs a new page scans the pages for an unused one, fills its slots into
//   the class list (one slot per cycle, up to 255 slots), then pops the head.
//   free: page read, offset check, link check, push; a reclaimed page then
//   unlinks each slot with a read state and a write state (registered reads).
// Reset clears all class lists and marks every page unused; link and page
// memories need no clearing. A stalled o_rsp holds the response and blocks
// further requests until it is taken.
`default_nettype none
module size_class_slab_allocator
    import sca_pkg::*;
#(
    parameter int POOL_PAGES = POOL_PAGES_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sca_req_if.sink   i_req,
    sca_rsp_if.source o_rsp
);

    localparam int IDS = POOL_PAGES * SLOTS_PER_PAGE;
    localparam int AW  = $clog2(IDS);
    localparam int IW  = $clog2(IDS + 1);
    localparam int PW  = (POOL_PAGES > 1) ? $clog2(POOL_PAGES) : 1;
    localparam logic [IW-1:0] NIL = IW'(IDS);

    logic [IW-1:0] next_mem [IDS];
    logic [IW-1:0] prev_mem [IDS];
    logic [11:0]   page_mem [POOL_PAGES];

    t_state          r_state, n_state;
    logic [IW-1:0]   r_head [CLASS_COUNT];
    logic [IW-1:0]   n_head [CLASS_COUNT];
    logic [POOL_PAGES-1:0] r_busy, n_busy;
    t_cls            r_cls, n_cls;
    logic [PW-1:0]   r_page, n_page;
    logic [7:0]      r_slot, n_slot;
    logic [IW-1:0]   r_id, n_id;
    logic [IW-1:0]   r_h, n_h;
    logic [7:0]      r_live, n_live;
    logic [11:0]     r_off, n_off;
    logic            r_o_valid, n_o_valid;
    logic [15:0]     r_o_addr, n_o_addr;
    logic [1:0]      r_o_status, n_o_status;

    logic [IW-1:0]   r_next_q, r_prev_q;
    logic [11:0]     r_pg_q;

    logic            next_we, prev_we, pg_we;
    logic [IW-1:0]   next_wa, next_wd, prev_wa, prev_wd, next_ra, prev_ra;
    logic [PW-1:0]   pg_wa, pg_ra;
    logic [11:0]     pg_wd;

    logic            accept;
    t_cls            in_cls;
    logic            in_big;
    logic [3:0]      in_pg;
    logic            in_ok;
    logic [7:0]      cur_cnt;
    logic [IW-1:0]   cur_id;
    t_cls            q_cls;
    logic [7:0]      q_live;
    logic [11:0]     off16;
    logic [11:0]     mask;
    logic [7:0]      chk_slot;
    logic            chk_ok;
    logic [7:0]      dec_live;
    logic            scan_last;

    function automatic logic [IW-1:0] make_id(input logic [PW-1:0] pg, input logic [7:0] s);
        return IW'({pg, s});
    endfunction

    function automatic logic [PW-1:0] id_page(input logic [IW-1:0] id);
        return PW'(id >> 8);
    endfunction

    assign accept      = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE) && (!r_o_valid || o_rsp.ready);
    assign o_rsp.valid = r_o_valid;
    assign o_rsp.granted_address = r_o_addr;
    assign o_rsp.status = r_o_status;

    assign in_cls  = size_class(i_req.request_size);
    assign in_big  = i_req.request_size > MAX_REQUEST;
    assign in_pg   = i_req.block_address[15:12];
    assign in_ok   = (32'(in_pg) < POOL_PAGES) && r_busy[PW'(in_pg)]
                     && (i_req.block_address[11:0] >= HEADER_BYTES);
    assign cur_cnt = slot_count(r_cls);
    assign cur_id  = make_id(r_page, r_slot);
    assign q_cls   = r_pg_q[11:8];
    assign q_live  = r_pg_q[7:0];
    assign off16   = r_off - HEADER_BYTES;
    assign mask    = (q_cls < 4'd8) ? 12'((13'd1 << (q_cls + 4'd4)) - 13'd1) : 12'hFFF;
    assign chk_slot = (q_cls < 4'd8) ? 8'(off16 >> (q_cls + 4'd4)) : 8'd0;
    assign chk_ok  = (q_cls < 4'(CLASS_COUNT)) && ((off16 & mask) == 12'd0)
                     && (chk_slot < slot_count(q_cls));
    assign dec_live = (r_live > 8'd0) ? r_live - 8'd1 : 8'd0;
    assign scan_last = (32'(r_page) == POOL_PAGES - 1);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_req.opcode == OP_FREE) n_state = in_ok ? S_FREE_RD : S_IDLE;
                    else if (in_big) n_state = S_IDLE;
                    else if (r_head[in_cls] != NIL) n_state = S_POP_RD;
                    else n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_busy[r_page]) n_state = S_FILL;
                else if (scan_last) n_state = S_IDLE;
            end
            S_FILL:     if (r_slot == cur_cnt - 8'd1) n_state = S_POP_RD;
            S_POP_RD:   n_state = S_POP_WR;
            S_POP_WR:   n_state = S_IDLE;
            S_FREE_RD:  n_state = S_FREE_CHK;
            S_FREE_CHK: n_state = chk_ok ? S_FREE_LNK : S_IDLE;
            S_FREE_LNK: n_state = (r_next_q == r_id) ? S_PUSH_A : S_IDLE;
            S_PUSH_A:   n_state = S_PUSH_B;
            S_PUSH_B:   n_state = (dec_live == 8'd0) ? S_UNL_RD : S_IDLE;
            S_UNL_RD:   n_state = S_UNL_WR;
            S_UNL_WR:   if (r_slot == cur_cnt - 8'd1) n_state = S_IDLE; else n_state = S_UNL_RD;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head = r_head;
        n_busy = r_busy;
        n_cls = r_cls;
        n_page = r_page;
        n_slot = r_slot;
        n_id = r_id;
        n_h = r_h;
        n_live = r_live;
        n_off = r_off;
        n_o_valid = r_o_valid && !o_rsp.ready;
        n_o_addr = r_o_addr;
        n_o_status = r_o_status;
        next_we = 1'b0; next_wa = r_id; next_wd = r_id;
        prev_we = 1'b0; prev_wa = r_id; prev_wd = NIL;
        next_ra = cur_id; prev_ra = cur_id;
        pg_we = 1'b0; pg_wa = r_page; pg_wd = {r_cls, 8'd0};
        pg_ra = r_page;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cls = in_cls;
                    n_page = PW'(in_pg);
                    n_off = i_req.block_address[11:0];
                    n_slot = 8'd0;
                    if (i_req.opcode == OP_FREE) begin
                        if (!in_ok) begin
                            n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_OK;
                        end
                    end else if (in_big) begin
                        n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_TOO_BIG;
                    end else if (r_head[in_cls] == NIL) begin
                        n_page = '0;
                    end
                end
            end
            S_SCAN: begin
                if (!r_busy[r_page]) begin
                    n_busy[r_page] = 1'b1;
                    pg_we = 1'b1;
                    pg_wd = {r_cls, 8'd0};
                end else if (scan_last) begin
                    n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_NO_PAGE;
                end else begin
                    n_page = r_page + PW'(1);
                end
            end
            S_FILL: begin
                next_we = 1'b1; next_wa = cur_id;
                next_wd = (r_slot == 8'd0) ? NIL : cur_id - IW'(1);
                prev_we = 1'b1; prev_wa = cur_id;
                prev_wd = (r_slot == cur_cnt - 8'd1) ? NIL : cur_id + IW'(1);
                if (r_slot == cur_cnt - 8'd1) n_head[r_cls] = cur_id;
                else n_slot = r_slot + 8'd1;
            end
            S_POP_RD: begin
                next_ra = r_head[r_cls];
                pg_ra = id_page(r_head[r_cls]);
                n_id = r_head[r_cls];
            end
            S_POP_WR: begin
                n_head[r_cls] = r_next_q;
                next_we = 1'b1; next_wa = r_id; next_wd = r_id;
                prev_we = r_next_q != NIL; prev_wa = r_next_q; prev_wd = NIL;
                pg_we = 1'b1; pg_wa = id_page(r_id);
                pg_wd = {r_cls, r_pg_q[7:0] + 8'd1};
                n_o_valid = 1'b1; n_o_status = ST_OK;
                n_o_addr = 16'({id_page(r_id), HEADER_BYTES + slot_offset(r_cls, r_id[7:0])});
            end
            S_FREE_RD: ;
            S_FREE_CHK: begin
                n_cls = q_cls;
                n_live = q_live;
                n_slot = chk_slot;
                n_id = make_id(r_page, chk_slot);
                next_ra = make_id(r_page, chk_slot);
                if (!chk_ok) begin
                    n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_OK;
                end
            end
            S_FREE_LNK: begin
                if (r_next_q != r_id) begin
                    n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_OK;
                end
            end
            S_PUSH_A: begin
                n_h = r_head[r_cls];
                next_we = 1'b1; next_wa = r_id; next_wd = r_head[r_cls];
                prev_we = 1'b1; prev_wa = r_id; prev_wd = NIL;
            end
            S_PUSH_B: begin
                prev_we = r_h != NIL; prev_wa = r_h; prev_wd = r_id;
                n_head[r_cls] = r_id;
                pg_we = 1'b1; pg_wd = {r_cls, dec_live};
                n_slot = 8'd0;
                if (dec_live != 8'd0) begin
                    n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_OK;
                end
            end
            S_UNL_RD: ;
            S_UNL_WR: begin
                if (r_prev_q != NIL) begin
                    next_we = 1'b1; next_wa = r_prev_q; next_wd = r_next_q;
                end else begin
                    n_head[r_cls] = r_next_q;
                end
                prev_we = r_next_q != NIL; prev_wa = r_next_q; prev_wd = r_prev_q;
                if (r_slot == cur_cnt - 8'd1) begin
                    n_busy[r_page] = 1'b0;
                    n_o_valid = 1'b1; n_o_addr = 16'd0; n_o_status = ST_OK;
                end else begin
                    n_slot = r_slot + 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[AW'(next_wa)] <= next_wd;
        r_next_q <= next_mem[AW'(next_ra)];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) prev_mem[AW'(prev_wa)] <= prev_wd;
        r_prev_q <= prev_mem[AW'(prev_ra)];
    end

    always_ff @(posedge i_clk) begin
        if (pg_we) page_mem[pg_wa] <= pg_wd;
        r_pg_q <= page_mem[pg_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= '0;
            r_o_valid <= 1'b0;
            for (int k = 0; k < CLASS_COUNT; k++) r_head[k] <= NIL;
        end else begin
            r_state <= n_state;
            r_busy <= n_busy;
            r_o_valid <= n_o_valid;
            r_head <= n_head;
        end
        r_cls <= n_cls;
        r_page <= n_page;
        r_slot <= n_slot;
        r_id <= n_id;
        r_h <= n_h;
        r_live <= n_live;
        r_off <= n_off;
        r_o_addr <= n_o_addr;
        r_o_status <= n_o_status;
    end

endmodule
`default_nettype wire
